/* rtl/wns_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wns_pkg
// hash constants and output limits shared by the worley noise sample unit
// ----------------------------------------------------------------------------
package wns_pkg;

	localparam logic [31:0] MIX_X   = 32'h27d4eb2d;
	localparam logic [31:0] MIX_Y   = 32'h85ebca6b;
	localparam logic [31:0] MIX_A   = 32'h2c1b3c6d;
	localparam logic [31:0] MIX_B   = 32'h297a2d39;
	localparam logic [31:0] MASK_X  = 32'h68bc21eb;
	localparam logic [31:0] MASK_Y  = 32'h02e5be93;
	localparam int          OUT_W   = 17;
	localparam logic [OUT_W-1:0] OUT_MAX = 17'h1ffff;

endpackage

/* rtl/wns_hash.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wns_hash
// four-stage pipelined seeded multiply-xorshift cell hash, last xorshift
// left to the consumer
// ----------------------------------------------------------------------------
module wns_hash
	import wns_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] seed,
	input  logic [31:0] cx,
	input  logic [31:0] cy,
	output logic [31:0] h
);

	logic [31:0] mx_s1, my_s1;
	logic [31:0] mix_s2;
	logic [31:0] a_s3;
	logic [31:0] b_s4;
	logic [31:0] mix_c, a_c;

	assign mix_c = seed ^ mx_s1 ^ my_s1;
	assign a_c   = a_s3 ^ (a_s3 >> 12);

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1  <= cx * MIX_X;
			my_s1  <= cy * MIX_Y;
			mix_s2 <= mix_c ^ (mix_c >> 15);
			a_s3   <= mix_s2 * MIX_A;
			b_s4   <= a_c * MIX_B;
		end
	end

	assign h = b_s4;

endmodule

/* rtl/wns_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wns_cell
// one neighbour cell: feature point hashes, deltas and squared distance,
// eight register stages
// ----------------------------------------------------------------------------
module wns_cell
	import wns_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter int OX        = 0,
	parameter int OY        = 0
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [31:0]            seed,
	input  logic [31:0]            cellx,
	input  logic [31:0]            celly,
	input  logic [FRAC_BITS-1:0]   fracx,
	input  logic [FRAC_BITS-1:0]   fracy,
	output logic [2*FRAC_BITS+2:0] d2
);

	localparam int DW = FRAC_BITS + 2;
	localparam int SW = 2 * FRAC_BITS + 3;
	localparam int BX = OX * (1 << FRAC_BITS);
	localparam int BY = OY * (1 << FRAC_BITS);

	logic [31:0] cx_s1, cy_s1;
	logic [FRAC_BITS-1:0] frx_s [1:5];
	logic [FRAC_BITS-1:0] fry_s [1:5];
	logic [31:0] hx_raw, hy_raw, hx, hy;
	logic signed [DW-1:0] offx, offy, fx, fy, dx_c, dy_c;
	logic signed [DW-1:0] dx_s6, dy_s6;
	logic signed [2*DW-1:0] sqx_c, sqy_c;
	logic [SW-1:0] sqx_s7, sqy_s7;
	logic [SW-1:0] d2_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1  <= cellx + 32'(OX);
			cy_s1  <= celly + 32'(OY);
			frx_s[1] <= fracx;
			fry_s[1] <= fracy;
			for (int i = 2; i <= 5; i++) begin
				frx_s[i] <= frx_s[i-1];
				fry_s[i] <= fry_s[i-1];
			end
		end
	end

	wns_hash u_hash_x (
		.clk  (clk),
		.en   (en),
		.seed (seed),
		.cx   (cx_s1),
		.cy   (cy_s1),
		.h    (hx_raw)
	);

	wns_hash u_hash_y (
		.clk  (clk),
		.en   (en),
		.seed (seed),
		.cx   (cx_s1 ^ MASK_X),
		.cy   (cy_s1 ^ MASK_Y),
		.h    (hy_raw)
	);

	assign hx   = hx_raw ^ (hx_raw >> 15);
	assign hy   = hy_raw ^ (hy_raw >> 15);
	assign offx = $signed({2'b00, hx[31 -: FRAC_BITS]});
	assign offy = $signed({2'b00, hy[31 -: FRAC_BITS]});
	assign fx   = $signed({2'b00, frx_s[5]});
	assign fy   = $signed({2'b00, fry_s[5]});
	assign dx_c = offx - fx + DW'(BX);
	assign dy_c = offy - fy + DW'(BY);
	assign sqx_c = dx_s6 * dx_s6;
	assign sqy_c = dy_s6 * dy_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s6  <= dx_c;
			dy_s6  <= dy_c;
			sqx_s7 <= sqx_c[SW-1:0];
			sqy_s7 <= sqy_c[SW-1:0];
			d2_s8  <= sqx_s7 + sqy_s7;
		end
	end

	assign d2 = d2_s8;

endmodule

/* rtl/wns_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wns_sqrt
// pipelined floor square root, one root bit per register stage
// ----------------------------------------------------------------------------
module wns_sqrt #(
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [2*FRAC_BITS+2:0] v,
	output logic [FRAC_BITS+1:0]   root
);

	localparam int RW  = FRAC_BITS + 2;
	localparam int VW  = 2 * RW;
	localparam int RMW = RW + 3;

	logic [RMW-1:0] rem_s  [0:RW];
	logic [RW-1:0]  root_s [0:RW];
	logic [VW-1:0]  vv_s   [0:RW];

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign vv_s[0]   = {1'b0, v};

	for (genvar i = 0; i < RW; i++) begin : g_stage
		logic [RMW-1:0] r2, t;
		assign r2 = {rem_s[i][RMW-3:0], vv_s[i][VW-1 -: 2]};
		assign t  = {1'b0, root_s[i], 2'b01};
		always_ff @(posedge clk) begin
			if (en) begin
				vv_s[i+1] <= {vv_s[i][VW-3:0], 2'b00};
				if (r2 >= t) begin
					rem_s[i+1]  <= r2 - t;
					root_s[i+1] <= {root_s[i][RW-2:0], 1'b1};
				end else begin
					rem_s[i+1]  <= r2;
					root_s[i+1] <= {root_s[i][RW-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_s[RW];

endmodule

/* rtl/worley_noise_sample_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// worley_noise_sample_unit
// 2d f1 worley noise, one q16.16 point in, one q1.16 distance out
// ----------------------------------------------------------------------------
// point_x / point_y transfer on in_valid & in_ready; nearest_distance
// transfers on out_valid & out_ready. noise_seed is written through the
// cfg channel (cfg_ready is always high); the user must write it only
// while the unit holds no item, since the unit does not enforce this.
// after an input register, the nine neighbour cells are evaluated in
// parallel, each with two pipelined hash units; a two-level min tree,
// a one-bit-per-stage square root and an output register follow.
// throughput: one point per cycle while the output is not stalled,
// with every stage advancing together.
// when the receiver stalls with a result waiting, the whole pipeline
// freezes and in_ready drops; nothing is lost or repeated. while the
// output register is empty in_ready stays high.
// reset clears all valid bits and sets the stored seed to zero.
// ----------------------------------------------------------------------------
module worley_noise_sample_unit
	import wns_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        noise_seed,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [OUT_W-1:0]   nearest_distance
);

	localparam int RW = FRAC_BITS + 2;
	localparam int SW = 2 * FRAC_BITS + 3;
	localparam int L  = 1 + 8 + 2 + RW + 1;

	logic          adv;
	logic [L-1:0]  vld_q;
	logic [31:0]   seed_q;
	logic [31:0]   cellx_s1, celly_s1;
	logic [FRAC_BITS-1:0] fracx_c, fracy_c, fracx_s1, fracy_s1;
	logic [SW-1:0] d2_c [0:8];
	logic [SW-1:0] min_s10 [0:2];
	logic [SW-1:0] min_s11;
	logic [RW-1:0] root_c;
	logic [17:0]   scaled_c;
	logic [OUT_W-1:0] dist_q;

	function automatic logic [SW-1:0] min2(input logic [SW-1:0] a, input logic [SW-1:0] b);
		return (b < a) ? b : a;
	endfunction

	assign adv       = !vld_q[L-1] || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;
	assign out_valid = vld_q[L-1];
	assign nearest_distance = dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			seed_q <= '0;
		end else begin
			if (adv) vld_q <= {vld_q[L-2:0], in_valid};
			if (cfg_valid) seed_q <= noise_seed;
		end
	end

	if (FRAC_BITS >= 16) begin : g_frac_up
		assign fracx_c = FRAC_BITS'({point_x[15:0], {(FRAC_BITS-16+1){1'b0}}} >> 1);
		assign fracy_c = FRAC_BITS'({point_y[15:0], {(FRAC_BITS-16+1){1'b0}}} >> 1);
	end else begin : g_frac_dn
		assign fracx_c = point_x[15 -: FRAC_BITS];
		assign fracy_c = point_y[15 -: FRAC_BITS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cellx_s1 <= {{16{point_x[31]}}, point_x[31:16]};
			celly_s1 <= {{16{point_y[31]}}, point_y[31:16]};
			fracx_s1 <= fracx_c;
			fracy_s1 <= fracy_c;
		end
	end

	for (genvar k = 0; k < 9; k++) begin : g_cell
		wns_cell #(
			.FRAC_BITS (FRAC_BITS),
			.OX        ((k % 3) - 1),
			.OY        ((k / 3) - 1)
		) u_cell (
			.clk   (clk),
			.en    (adv),
			.seed  (seed_q),
			.cellx (cellx_s1),
			.celly (celly_s1),
			.fracx (fracx_s1),
			.fracy (fracy_s1),
			.d2    (d2_c[k])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				min_s10[j] <= min2(min2(d2_c[3*j], d2_c[3*j+1]), d2_c[3*j+2]);
			end
			min_s11 <= min2(min2(min_s10[0], min_s10[1]), min_s10[2]);
		end
	end

	wns_sqrt #(
		.FRAC_BITS (FRAC_BITS)
	) u_sqrt (
		.clk  (clk),
		.en   (adv),
		.v    (min_s11),
		.root (root_c)
	);

	if (FRAC_BITS >= 16) begin : g_out_dn
		assign scaled_c = root_c[RW-1 -: 18];
	end else begin : g_out_up
		assign scaled_c = {root_c, {(16-FRAC_BITS){1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (adv) dist_q <= scaled_c[17] ? OUT_MAX : scaled_c[OUT_W-1:0];
	end

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(vld_q) && $stable(dist_q))
		else $error("pipeline moved during output stall");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output stage");

	a_seed_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |=> seed_q == $past(noise_seed))
		else $error("seed write lost");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted point not tracked");

endmodule
